// ===== src/bpq_pkg.sv =====
// Shared types and constants of the battery presence qualifier.
// Used by bpq_ctrl, bpq_datapath, battery_presence_qualifier and bpq_checker.
package bpq_pkg;

    // Default parameter values
    localparam int ADC_MV_BITS_DEF    = 12;
    localparam int RUN_COUNT_BITS_DEF = 8;

    // Field and register widths
    localparam int GAIN_W      = 18;
    localparam int MV_W        = 14;
    localparam int CONF_W      = 8;
    localparam int PCT_W       = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int OUT_TDATA_W = 32;

    // Q16 gain rounding
    localparam int Q_FRAC = 16;

    localparam logic [MV_W-1:0] MV_MAX = 14'h3FFF;

    // Percent curve: ((mv - 3300) * 100 + 450) / 900, the divide by 900
    // done as multiply by ceil(2^25 / 900) and shift; exact for numerators
    // below 2^25 / 268.
    localparam int                 PCT_NUM_W   = 17;
    localparam int                 PCT_RECIP_W = 16;
    localparam int                 PCT_SHIFT   = 25;
    localparam logic [MV_W-1:0]    PCT_LOW_MV  = 14'd3300;
    localparam logic [MV_W-1:0]    PCT_HIGH_MV = 14'd4200;
    localparam logic [PCT_W-1:0]   PCT_SCALE   = 7'd100;
    localparam logic [PCT_NUM_W-1:0] PCT_ROUND = 17'd450;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 16'd37283;
    localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_EMPTY   = 7'd0;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_RST        = 18'd200428;
    localparam logic [MV_W-1:0]   ARTIFACT_MV_RST = 14'd4240;
    localparam logic [MV_W-1:0]   MIN_MV_RST      = 14'd3200;
    localparam logic [MV_W-1:0]   MAX_MV_RST      = 14'd4180;
    localparam logic [CONF_W-1:0] USB_CONF_RST    = 8'd1;
    localparam logic [CONF_W-1:0] BATT_CONF_RST   = 8'd12;
    localparam logic [CONF_W-1:0] NONE_CONF_RST   = 8'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN        = 3'd0,
        CFG_ARTIFACT_MV = 3'd1,
        CFG_MIN_MV      = 3'd2,
        CFG_MAX_MV      = 3'd3,
        CFG_USB_CONF    = 3'd4,
        CFG_BATT_CONF   = 3'd5,
        CFG_NONE_CONF   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_UNKNOWN = 2'd0,
        ST_USB     = 2'd1,
        ST_BATT    = 2'd2,
        ST_NONE    = 2'd3
    } t_bpq_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mul;
        logic scale;
        logic classify;
        logic load_out;
    } t_bpq_cmd;

    // Result as packed on the output tdata, lowest field last
    typedef struct packed {
        logic [OUT_TDATA_W-MV_W-PCT_W-6-1:0] pad;
        logic [MV_W-1:0]  battery_mv;
        logic [PCT_W-1:0] charge_pct;
        logic             usb_flag;
        logic             batt_flag;
        logic [1:0]       instant_state;
        logic [1:0]       qual_state;
    } t_bpq_result;

endpackage

// ===== src/bpq_ctrl.sv =====
// Sequencer of the battery presence qualifier: one-hot state machine and
// output valid flag. Depends on bpq_pkg.
module bpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bpq_pkg::t_bpq_cmd  o_cmd
);
    import bpq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_SCALE = 5'b00100,
        S_CLASS = 5'b01000,
        S_PCT   = 5'b10000
    } t_fsm;

    t_fsm r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_out_free;
    logic w_accept;

    // output register free now or freed by this cycle's transaction
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_PCT) && w_out_free);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.load_in  = w_accept;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.scale    = (r_state == S_SCALE);
        o_cmd.classify = (r_state == S_CLASS);
        o_cmd.load_out = (r_state == S_PCT) && w_out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = w_accept ? S_MUL : S_IDLE;
            S_MUL:   n_state = S_SCALE;
            S_SCALE: n_state = S_CLASS;
            S_CLASS: n_state = S_PCT;
            S_PCT: begin
                if (w_out_free) begin
                    n_state = w_accept ? S_MUL : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/bpq_datapath.sv =====
// Datapath of the battery presence qualifier: config registers, gain multiply,
// classification with run counters, percent and output register. Uses bpq_pkg.
module bpq_datapath #(
    parameter int ADC_MV_BITS    = bpq_pkg::ADC_MV_BITS_DEF,
    parameter int RUN_COUNT_BITS = bpq_pkg::RUN_COUNT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bpq_pkg::t_bpq_cmd                     i_cmd,
    input  logic                                  i_cfg_we,
    input  logic [bpq_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bpq_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic [ADC_MV_BITS-1:0]                i_adc,
    output bpq_pkg::t_bpq_result                  o_result
);
    import bpq_pkg::*;

    localparam int PROD_W = ADC_MV_BITS + GAIN_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SC_W   = SUM_W - Q_FRAC;
    localparam int EXT_W  = (SC_W > MV_W) ? SC_W : MV_W;
    localparam int CMP_W  = (RUN_COUNT_BITS > CONF_W) ? RUN_COUNT_BITS : CONF_W;
    localparam int PCT_PROD_W = PCT_NUM_W + PCT_RECIP_W;

    localparam logic [SUM_W-1:0]          ROUND_HALF = SUM_W'(1) << (Q_FRAC - 1);
    localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX    = '1;

    // configuration
    logic [GAIN_W-1:0] r_gain;
    logic [MV_W-1:0]   r_artifact_mv;
    logic [MV_W-1:0]   r_min_mv;
    logic [MV_W-1:0]   r_max_mv;
    logic [CONF_W-1:0] r_usb_conf;
    logic [CONF_W-1:0] r_batt_conf;
    logic [CONF_W-1:0] r_none_conf;

    // qualifier state
    t_bpq_state                r_qual, n_qual;
    logic [RUN_COUNT_BITS-1:0] r_usb_run, n_usb_run;
    logic [RUN_COUNT_BITS-1:0] r_batt_run, n_batt_run;
    logic [RUN_COUNT_BITS-1:0] r_none_run, n_none_run;

    // per-item payload
    logic [ADC_MV_BITS-1:0] r_adc;
    logic [PROD_W-1:0]      r_prod;
    logic [MV_W-1:0]        r_mv;
    t_bpq_state             r_inst, n_inst;
    logic                   r_pct_lo, r_pct_hi;
    logic [PCT_NUM_W-1:0]   r_num;
    t_bpq_result            r_result;

    logic [SUM_W-1:0]       w_sum;
    logic [EXT_W-1:0]       w_scaled;
    logic [MV_W-1:0]        w_mv;
    logic [MV_W-1:0]        w_dmv;
    logic [PCT_NUM_W-1:0]   w_num;
    logic [PCT_PROD_W-1:0]  w_pct_prod;
    logic [PCT_W-1:0]       w_pct;

    function automatic logic [RUN_COUNT_BITS-1:0] bump(input logic [RUN_COUNT_BITS-1:0] run);
        bump = (run == RUN_MAX) ? run : run + RUN_COUNT_BITS'(1);
    endfunction

    function automatic logic reached(input logic [RUN_COUNT_BITS-1:0] run,
                                     input logic [CONF_W-1:0] conf);
        reached = CMP_W'(run) >= CMP_W'(conf);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain        <= GAIN_RST;
            r_artifact_mv <= ARTIFACT_MV_RST;
            r_min_mv      <= MIN_MV_RST;
            r_max_mv      <= MAX_MV_RST;
            r_usb_conf    <= USB_CONF_RST;
            r_batt_conf   <= BATT_CONF_RST;
            r_none_conf   <= NONE_CONF_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN:        r_gain        <= i_cfg_wdata[GAIN_W-1:0];
                CFG_ARTIFACT_MV: r_artifact_mv <= i_cfg_wdata[MV_W-1:0];
                CFG_MIN_MV:      r_min_mv      <= i_cfg_wdata[MV_W-1:0];
                CFG_MAX_MV:      r_max_mv      <= i_cfg_wdata[MV_W-1:0];
                CFG_USB_CONF:    r_usb_conf    <= i_cfg_wdata[CONF_W-1:0];
                CFG_BATT_CONF:   r_batt_conf   <= i_cfg_wdata[CONF_W-1:0];
                CFG_NONE_CONF:   r_none_conf   <= i_cfg_wdata[CONF_W-1:0];
                default: ;
            endcase
        end
    end

    // rounding shift of the Q16 product, then clamp to the 14-bit range
    assign w_sum    = SUM_W'(r_prod) + ROUND_HALF;
    assign w_scaled = EXT_W'(w_sum[SUM_W-1:Q_FRAC]);
    assign w_mv     = (w_scaled > EXT_W'(MV_MAX)) ? MV_MAX : w_scaled[MV_W-1:0];

    // classification; artifact wins over the present window
    always_comb begin
        n_qual     = r_qual;
        n_usb_run  = '0;
        n_batt_run = '0;
        n_none_run = '0;
        if (r_mv >= r_artifact_mv) begin
            n_inst    = ST_USB;
            n_usb_run = bump(r_usb_run);
            if (reached(n_usb_run, r_usb_conf)) begin
                n_qual = ST_USB;
            end
        end else if ((r_mv >= r_min_mv) && (r_mv <= r_max_mv)) begin
            n_inst     = ST_BATT;
            n_batt_run = bump(r_batt_run);
            if (reached(n_batt_run, r_batt_conf)) begin
                n_qual = ST_BATT;
            end
        end else begin
            n_inst     = ST_NONE;
            n_none_run = bump(r_none_run);
            if (reached(n_none_run, r_none_conf)) begin
                n_qual = ST_NONE;
            end
        end
    end

    // numerator only matters inside the curve, where mv - 3300 fits 10 bits
    assign w_dmv = r_mv - PCT_LOW_MV;
    assign w_num = PCT_NUM_W'(w_dmv[9:0]) * PCT_NUM_W'(PCT_SCALE) + PCT_ROUND;

    assign w_pct_prod = PCT_PROD_W'(r_num) * PCT_PROD_W'(PCT_RECIP);
    always_comb begin
        if (r_pct_hi) begin
            w_pct = PCT_FULL;
        end else if (r_pct_lo) begin
            w_pct = PCT_EMPTY;
        end else begin
            w_pct = w_pct_prod[PCT_SHIFT +: PCT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qual     <= ST_UNKNOWN;
            r_usb_run  <= '0;
            r_batt_run <= '0;
            r_none_run <= '0;
        end else if (i_cmd.classify) begin
            r_qual     <= n_qual;
            r_usb_run  <= n_usb_run;
            r_batt_run <= n_batt_run;
            r_none_run <= n_none_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_adc <= i_adc;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_adc) * PROD_W'(r_gain);
        end
        if (i_cmd.scale) begin
            r_mv <= w_mv;
        end
        if (i_cmd.classify) begin
            r_inst   <= n_inst;
            r_pct_lo <= (r_mv <= PCT_LOW_MV);
            r_pct_hi <= (r_mv >= PCT_HIGH_MV);
            r_num    <= w_num;
        end
        if (i_cmd.load_out) begin
            r_result.pad           <= '0;
            r_result.battery_mv    <= r_mv;
            r_result.charge_pct    <= (r_qual == ST_BATT) ? w_pct : PCT_EMPTY;
            r_result.usb_flag      <= (r_qual == ST_USB);
            r_result.batt_flag     <= (r_qual == ST_BATT);
            r_result.instant_state <= r_inst;
            r_result.qual_state    <= r_qual;
        end
    end

    assign o_result = r_result;

endmodule

// ===== src/battery_presence_qualifier.sv =====
// Each sample passes the multiply, scale, classify and percent steps of the
// sequencer in turn; a stalled output register holds the last step.
// A new sample is taken while the previous result waits in the output register.
// Reset: synchronous, active low; config to defaults, state unknown, counters 0.
// Top level; instantiates bpq_ctrl and bpq_datapath, uses bpq_pkg.
module battery_presence_qualifier #(
    parameter int ADC_MV_BITS    = bpq_pkg::ADC_MV_BITS_DEF,
    parameter int RUN_COUNT_BITS = bpq_pkg::RUN_COUNT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bpq_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bpq_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [ADC_MV_BITS-1:0] adc_millivolts, rest zero
    input  logic [((ADC_MV_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [1:0] qual_state, [3:2] instant_state, [4] batt_flag,
    // [5] usb_flag, [12:6] charge_pct, [26:13] battery_mv, rest zero
    output logic [bpq_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);
    import bpq_pkg::*;

    t_bpq_cmd    w_cmd;
    t_bpq_result w_result;

    bpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd)
    );

    bpq_datapath #(
        .ADC_MV_BITS    (ADC_MV_BITS),
        .RUN_COUNT_BITS (RUN_COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adc       (i_s_axis_tdata[ADC_MV_BITS-1:0]),
        .o_result    (w_result)
    );

    assign o_m_axis_tdata = w_result;

endmodule

// ===== src/bpq_checker.sv =====
// Port-level assertions for battery_presence_qualifier, attached by bind.
// Uses bpq_pkg for the output width.
module bpq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [bpq_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import bpq_pkg::*;

    logic w_in_xact;
    assign w_in_xact = i_s_axis_tvalid && o_s_axis_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("output changed while stalled");

    // one sample in flight: no transaction right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xact |=> !o_s_axis_tready)
        else $error("input ready right after a transaction");

    // each rise of tvalid traces back to its sample's input transaction
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_in_xact, 5))
        else $error("result without matching input transaction");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind battery_presence_qualifier bpq_checker u_bpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
